FILE: src/fss_pkg.sv
// Package for the fuzzy subsequence scorer: widths, action codes, character
// constants, score weights and the classified word passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package fss_pkg;

  localparam int MAX_QUERY = 64;
  localparam int QA_W      = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int QLEN_W    = $clog2(MAX_QUERY + 1);
  localparam int ACT_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int SCORE_W   = 16;
  localparam int SUM_W     = SCORE_W + 2;
  localparam int CNT_W     = QLEN_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_PATH   = 2'd2
  } action_t;

  localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'd95;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'd45;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'd122;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;

  localparam int BONUS_W = 7;
  localparam logic [BONUS_W-1:0] PTS_MATCH    = 7'd16;
  localparam logic [BONUS_W-1:0] PTS_BOUNDARY = 7'd30;
  localparam logic [BONUS_W-1:0] PTS_RUN      = 7'd15;
  localparam logic [BONUS_W-1:0] PTS_START    = 7'd20;

  // Classified word: folded byte plus the flags the scorer needs.
  typedef struct packed {
    action_t           op;
    logic [CHAR_W-1:0] folded;
    logic              is_upper;
    logic              is_lower;
    logic              is_sep;
    logic              is_slash;
    logic              last;
  } item_t;

endpackage

FILE: src/fss_in_if.sv
// Input channel of the fuzzy subsequence scorer: valid/ready plus payload.
// Depends on fss_pkg.
`timescale 1ns / 1ps

interface fss_in_if import fss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, action, char_code, last_char, input ready);
  modport sink   (input valid, action, char_code, last_char, output ready);
endinterface

FILE: src/fss_out_if.sv
// Result channel of the fuzzy subsequence scorer: valid/ready plus payload.
// Depends on fss_pkg.
`timescale 1ns / 1ps

interface fss_out_if import fss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      matched;
  logic signed [SCORE_W-1:0] score;

  modport source (output valid, matched, score, input ready);
  modport sink   (input valid, matched, score, output ready);
endinterface

FILE: src/fss_front.sv
// Front end: accepts input words, drops unused action codes, folds case and
// tags each byte with its character class. Depends on fss_pkg, fss_in_if.
`timescale 1ns / 1ps

module fss_front import fss_pkg::*; (
  fss_in_if.sink in_chan,
  input  logic   q_full,
  output logic   push,
  output item_t  push_item
);

  logic [CHAR_W-1:0] c;
  logic              up;

  assign c  = in_chan.char_code;
  assign up = (c >= CH_UP_A) && (c <= CH_UP_Z);

  assign in_chan.ready = !q_full;

  always_comb begin
    push = in_chan.valid && !q_full &&
           (in_chan.action inside {ACT_CLEAR, ACT_APPEND, ACT_PATH});
    push_item.op       = action_t'(in_chan.action);
    push_item.folded   = up ? (c + CASE_OFS) : c;
    push_item.is_upper = up;
    push_item.is_lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
    push_item.is_sep   = (c inside {CH_SLASH, CH_UNDER, CH_DASH, CH_DOT, CH_SPACE});
    push_item.is_slash = (c == CH_SLASH);
    // last only ends a path; drop it on query edits
    push_item.last     = in_chan.last_char && (in_chan.action == ACT_PATH);
  end

endmodule

FILE: src/fss_queue.sv
// Two-entry queue of classified words between front and back end.
// Depends on fss_pkg.
`timescale 1ns / 1ps

module fss_queue import fss_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t       slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

FILE: src/fss_back.sv
// Back end: query store, greedy match, scoring and the result register.
// Depends on fss_pkg, fss_out_if.
`timescale 1ns / 1ps

module fss_back import fss_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    pop_valid,
  input  item_t   pop_item,
  output logic    pop,
  fss_out_if.source out_chan
);

  function automatic logic signed [SCORE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2**(SCORE_W-1) - 1);
    lo = -SUM_W'(2**(SCORE_W-1));
    if (v > hi)      sat16 = SCORE_W'(hi);
    else if (v < lo) sat16 = SCORE_W'(lo);
    else             sat16 = v[SCORE_W-1:0];
  endfunction

  // query store, folded bytes
  logic [CHAR_W-1:0] qmem [MAX_QUERY];
  logic [CHAR_W-1:0] rd_r;      // store[qpos + 1]
  logic [CHAR_W-1:0] cur_r, cur_nxt;   // store[qpos]
  logic [CHAR_W-1:0] q0_r, q0_nxt;     // store[0]

  logic [QLEN_W-1:0] qlen_r, qlen_nxt;
  logic [QLEN_W-1:0] qpos_r, qpos_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic run_r, run_nxt;
  logic prev_sep_r, prev_sep_nxt;
  logic prev_lower_r, prev_lower_nxt;
  logic start_r, start_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_matched_r, out_matched_nxt;
  logic signed [SCORE_W-1:0] out_score_r, out_score_nxt;

  logic              take, do_path, do_append, do_clear, active, hit, miss, restart;
  logic              wr_en;
  logic [QA_W-1:0]   wr_addr, rd_addr;
  logic [BONUS_W-1:0] bonus;
  logic signed [SUM_W-1:0] step_sum, final_sum;
  logic [CNT_W+2:0]  pend_x10;
  logic              ok;

  assign take = pop_valid && (!out_valid_r || out_chan.ready);
  assign pop  = take;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.matched = out_matched_r;
  assign out_chan.score   = out_score_r;

  always_comb begin
    do_path   = take && (pop_item.op == ACT_PATH);
    do_append = take && (pop_item.op == ACT_APPEND);
    do_clear  = take && (pop_item.op == ACT_CLEAR);
    active    = (qpos_r < qlen_r);
    hit       = do_path && active && (pop_item.folded == cur_r);
    miss      = do_path && active && !hit;

    bonus = PTS_MATCH;
    if (prev_sep_r || (prev_lower_r && pop_item.is_upper)) bonus = bonus + PTS_BOUNDARY;
    if (run_r)   bonus = bonus + PTS_RUN;
    if (start_r) bonus = bonus + PTS_START;

    step_sum = SUM_W'(score_r) + (hit ? SUM_W'(bonus) : -SUM_W'(1));

    // path step
    score_nxt      = score_r;
    qpos_nxt       = qpos_r;
    pend_nxt       = pend_r;
    run_nxt        = run_r;
    prev_sep_nxt   = prev_sep_r;
    prev_lower_nxt = prev_lower_r;
    start_nxt      = start_r;
    cur_nxt        = cur_r;
    if (hit || miss) begin
      score_nxt      = sat16(step_sum);
      run_nxt        = hit;
      prev_sep_nxt   = pop_item.is_sep;
      prev_lower_nxt = pop_item.is_lower;
    end
    if (hit) begin
      qpos_nxt = qpos_r + QLEN_W'(1);
      pend_nxt = pend_r + CNT_W'(1);
      cur_nxt  = rd_r;
    end
    if (do_path) begin
      if (pop_item.is_slash) pend_nxt = '0;
      start_nxt = 1'b0;
    end

    // result of the path's last byte
    pend_x10  = {pend_nxt, 3'b000} + {2'b00, pend_nxt, 1'b0};
    final_sum = SUM_W'(score_nxt) + SUM_W'(pend_x10);
    ok        = (qpos_nxt >= qlen_r);

    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_matched_nxt = out_matched_r;
    out_score_nxt   = out_score_r;
    if (do_path && pop_item.last) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = ok;
      out_score_nxt   = (ok && (qlen_r != '0)) ? sat16(final_sum) : '0;
    end

    // query edits
    qlen_nxt = qlen_r;
    q0_nxt   = q0_r;
    wr_en    = 1'b0;
    wr_addr  = qlen_r[QA_W-1:0];
    if (do_clear) qlen_nxt = '0;
    if (do_append && (qlen_r < QLEN_W'(MAX_QUERY))) begin
      wr_en    = 1'b1;
      qlen_nxt = qlen_r + QLEN_W'(1);
      if (qlen_r == '0) q0_nxt = pop_item.folded;
    end

    // restart the path: back to store[0]
    restart = do_clear || do_append || (do_path && pop_item.last);
    if (restart) begin
      score_nxt      = '0;
      qpos_nxt       = '0;
      pend_nxt       = '0;
      run_nxt        = 1'b0;
      prev_sep_nxt   = 1'b1;
      prev_lower_nxt = 1'b0;
      start_nxt      = 1'b1;
      cur_nxt        = q0_nxt;
    end

    // prefetch store[qpos_nxt + 1]
    if (restart)  rd_addr = QA_W'(1);
    else if (hit) rd_addr = qpos_r[QA_W-1:0] + QA_W'(2);
    else          rd_addr = qpos_r[QA_W-1:0] + QA_W'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) qmem[wr_addr] <= pop_item.folded;
    rd_r <= (wr_en && (wr_addr == rd_addr)) ? pop_item.folded : qmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r       <= '0;
      qpos_r       <= '0;
      pend_r       <= '0;
      score_r      <= '0;
      run_r        <= 1'b0;
      prev_sep_r   <= 1'b1;
      prev_lower_r <= 1'b0;
      start_r      <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      qlen_r       <= qlen_nxt;
      qpos_r       <= qpos_nxt;
      pend_r       <= pend_nxt;
      score_r      <= score_nxt;
      run_r        <= run_nxt;
      prev_sep_r   <= prev_sep_nxt;
      prev_lower_r <= prev_lower_nxt;
      start_r      <= start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    q0_r          <= q0_nxt;
    out_matched_r <= out_matched_nxt;
    out_score_r   <= out_score_nxt;
  end

endmodule

FILE: src/fuzzy_subsequence_scorer.sv
// Top level of the fuzzy subsequence scorer: front end, queue, back end.
// Depends on fss_pkg, fss_in_if, fss_out_if, fss_front, fss_queue, fss_back.
`timescale 1ns / 1ps

// The scorer takes one word per clock on in_chan: clear the query, append a
// query byte (up to 64 are kept, more are ignored) or feed one path byte.
// Each path is matched greedily and case-insensitively against the query;
// the byte flagged last_char produces one result word on out_chan with
// matched and a saturating 16-bit score (0 when unmatched or the query is
// empty). Sustained rate is one word per cycle with no gaps for any mix of
// actions while results are taken: the query sits in a 64-byte store with
// one write and one read port, read once per cycle one entry ahead of the
// current match position, so a match never waits on a read. The last path
// byte passes through the two-word queue and its result is held in the
// output register. While a result waits to be taken the queue absorbs up to
// two more words, then the input stalls.
module fuzzy_subsequence_scorer import fss_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  fss_in_if.sink    in_chan,
  fss_out_if.source out_chan
);

  logic  push, pop, q_full, pop_valid;
  item_t push_item, pop_item;

  // classify bytes and gate on queue space
  fss_front u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // hold classified words until the back end is free
  fss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // match, score and drive the result word
  fss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule
